[hdl/blpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box leader clustering package
// Shared constants, payload structs and controller/datapath interface types.
// ----------------------------------------------------------------------------
package blpc_pkg;

	localparam int MAX_CLUSTERS = 64;
	localparam int COORD_W      = 16;
	localparam int IDX_W        = $clog2(MAX_CLUSTERS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int GAP_W        = COORD_W + 1;
	localparam int DIST_W       = 18;
	localparam int LABEL_W      = 6;
	localparam int TOTAL_W      = 7;
	localparam int PADDR_W      = 2;
	localparam int PDATA_W      = 32;

	localparam logic [PADDR_W-1:0] REG_SENSITIVITY = 2'd0;
	localparam logic [DIST_W-1:0]  SENS_RESET      = 18'd1024;

	typedef struct packed {
		logic                      first_of_cloud;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} point_t;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic               opened_new;
		logic               table_full;
		logic [DIST_W-1:0]  best_distance;
		logic [TOTAL_W-1:0] cluster_total;
	} result_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic decide;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic pipe_empty;
		logic out_busy;
	} dp_status_t;

endpackage

[hdl/blpc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box leader clustering controller
// Sequences load, table scan, drain of the distance pipeline and the update.
// ----------------------------------------------------------------------------
module blpc_ctrl
	import blpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       point_valid,
	output logic       point_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t state_q;

	always_comb begin
		point_stall = (state_q != ST_IDLE);
		cmd.load    = (state_q == ST_IDLE) && point_valid;
		cmd.scan    = (state_q == ST_SCAN);
		cmd.decide  = (state_q == ST_DECIDE) && !status.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (point_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (status.scan_done && status.pipe_empty) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (!status.out_busy) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hdl/blpc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box leader clustering datapath
// Box memory, pipelined distance scan, best tracking, box update and result.
// ----------------------------------------------------------------------------
module blpc_datapath
	import blpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        status,
	input  point_t            point,
	input  logic [DIST_W-1:0] sensitivity,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result
);

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
	} box_t;

	box_t box_mem [MAX_CLUSTERS];

	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic [CNT_W-1:0]          used_q;
	logic [CNT_W-1:0]          rd_idx_q;
	logic                      scan_go;

	box_t                      box_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic                      vld_s1;

	box_t                      box_s2;
	logic [IDX_W-1:0]          idx_s2;
	logic [DIST_W-1:0]         dist_s2;
	logic                      vld_s2;

	box_t                      best_box_q;
	logic [IDX_W-1:0]          best_idx_q;
	logic [DIST_W-1:0]         best_d_q;
	logic                      found_q;

	logic                      result_valid_q;
	result_t                   result_q;

	logic [DIST_W-1:0]         dist_s1;
	logic                      take_best;
	logic                      need_new;
	logic                      has_room;
	logic                      open_new;
	logic [IDX_W-1:0]          wr_addr;
	box_t                      wr_box;
	box_t                      grown_box;
	logic [CNT_W-1:0]          used_next;

	function automatic logic [GAP_W-1:0] axis_gap(
		input logic signed [COORD_W-1:0] p,
		input logic signed [COORD_W-1:0] lo,
		input logic signed [COORD_W-1:0] hi
	);
		logic signed [GAP_W-1:0] a;
		logic signed [GAP_W-1:0] b;
		logic signed [GAP_W-1:0] m;
		a = GAP_W'(p) - GAP_W'(hi);
		b = GAP_W'(lo) - GAP_W'(p);
		m = (a > b) ? a : b;
		return m[GAP_W-1] ? '0 : m;
	endfunction

	assign scan_go   = cmd.scan && (rd_idx_q != used_q);
	assign dist_s1   = DIST_W'(axis_gap(px_q, box_s1.min_x, box_s1.max_x))
	                 + DIST_W'(axis_gap(py_q, box_s1.min_y, box_s1.max_y))
	                 + DIST_W'(axis_gap(pz_q, box_s1.min_z, box_s1.max_z));
	assign take_best = vld_s2 && (!found_q || dist_s2 < best_d_q);

	always_comb begin
		need_new  = !found_q || (best_d_q > sensitivity);
		has_room  = (used_q < CNT_W'(MAX_CLUSTERS));
		open_new  = need_new && has_room;

		grown_box.min_x = (px_q < best_box_q.min_x) ? px_q : best_box_q.min_x;
		grown_box.max_x = (px_q > best_box_q.max_x) ? px_q : best_box_q.max_x;
		grown_box.min_y = (py_q < best_box_q.min_y) ? py_q : best_box_q.min_y;
		grown_box.max_y = (py_q > best_box_q.max_y) ? py_q : best_box_q.max_y;
		grown_box.min_z = (pz_q < best_box_q.min_z) ? pz_q : best_box_q.min_z;
		grown_box.max_z = (pz_q > best_box_q.max_z) ? pz_q : best_box_q.max_z;

		if (open_new) begin
			wr_addr      = used_q[IDX_W-1:0];
			wr_box.min_x = px_q;
			wr_box.max_x = px_q;
			wr_box.min_y = py_q;
			wr_box.max_y = py_q;
			wr_box.min_z = pz_q;
			wr_box.max_z = pz_q;
			used_next    = used_q + CNT_W'(1);
		end else begin
			wr_addr   = best_idx_q;
			wr_box    = grown_box;
			used_next = used_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) box_mem[wr_addr] <= wr_box;
		box_s1 <= box_mem[rd_idx_q[IDX_W-1:0]];
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		box_s2 <= box_s1;
		idx_s2 <= idx_s1;
		dist_s2 <= dist_s1;
		if (cmd.load) begin
			px_q <= point.coord_x;
			py_q <= point.coord_y;
			pz_q <= point.coord_z;
		end
		if (take_best) begin
			best_box_q <= box_s2;
			best_idx_q <= idx_s2;
			best_d_q   <= dist_s2;
		end
		if (cmd.decide) begin
			result_q.label         <= open_new ? LABEL_W'(used_q) : LABEL_W'(best_idx_q);
			result_q.opened_new    <= open_new;
			result_q.table_full    <= need_new && !has_room;
			result_q.best_distance <= open_new ? '0 : best_d_q;
			result_q.cluster_total <= TOTAL_W'(used_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q         <= '0;
			rd_idx_q       <= '0;
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			vld_s1 <= scan_go;
			vld_s2 <= vld_s1;
			if (cmd.load) begin
				rd_idx_q <= '0;
				found_q  <= 1'b0;
				if (point.first_of_cloud) used_q <= '0;
			end else begin
				if (scan_go) rd_idx_q <= rd_idx_q + CNT_W'(1);
				if (take_best) found_q <= 1'b1;
				if (cmd.decide) used_q <= used_next;
			end
			if (cmd.decide) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign status.scan_done  = (rd_idx_q == used_q);
	assign status.pipe_empty = !vld_s1 && !vld_s2;
	assign status.out_busy   = result_valid_q && result_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[hdl/box_leader_point_clustering.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box leader point clustering
// Takes a new item only after the last one is done: the scan makes one box
// memory read per cluster in use, N being the clusters in use (at most 64).
// The result then waits in an output register while result_stall holds it.
// Reset empties the cluster table and sets sensitivity to 1024; no clear pass.
// ----------------------------------------------------------------------------
module box_leader_point_clustering
	import blpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               point_valid,
	output logic               point_stall,
	input  point_t             point,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result
);

	logic [DIST_W-1:0] sensitivity_q;
	ctrl_cmd_t         cmd;
	dp_status_t        status;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SENSITIVITY) ? PDATA_W'(sensitivity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensitivity_q <= SENS_RESET;
		end else if (psel && penable && pwrite && (paddr == REG_SENSITIVITY)) begin
			sensitivity_q <= pwdata[DIST_W-1:0];
		end
	end

	blpc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.status      (status),
		.cmd         (cmd)
	);

	blpc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.point        (point),
		.sensitivity  (sensitivity_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
